// ===== sv/skt_pkg.sv =====
package skt_pkg;

    // Field widths of one transfer
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     handle;
    } entry_t;

    localparam int ENTRY_W = KEY_W + HANDLE_W;

endpackage

// ===== sv/sorted_key_table.sv =====
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   op, key, record_handle
// out       output     out_valid/out_stall status, found_handle, entry_count
//
// One item at a time. Binary search: each probe reads the midpoint, then compares;
// up to ceil(log2(count+1)) probes, then a closing step. A lookup then reads and
// checks the entry at the found place, if there is one; an insert moves each entry
// at or above that place up one (read, then write), then writes the new entry.
// Every result loads the output register; a full-table insert goes straight to it.
// Reset clears the entry count and control state, not the memory. A new item is
// taken while the previous result still waits on out_stall.
module sorted_key_table #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic signed [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::HANDLE_W-1:0]        record_handle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [skt_pkg::STATUS_W-1:0]        status,
    output logic [skt_pkg::HANDLE_W-1:0]        found_handle,
    output logic [skt_pkg::COUNT_W-1:0]         entry_count
);

    import skt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SH_RD = 3'd4;
    localparam logic [2:0] S_SH_WR = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic                    op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [HANDLE_W-1:0]     handle_reg, handle_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           src_reg, src_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [STATUS_W-1:0]     res_st_reg, res_st_next;
    logic [HANDLE_W-1:0]     res_fh_reg, res_fh_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [HANDLE_W-1:0]     found_handle_reg, found_handle_next;
    logic [COUNT_W-1:0]      entry_count_reg, entry_count_next;

    logic                    in_xfer;
    logic                    out_free;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_full;
    logic [CW-1:0]           fill_less1;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    entry_t                  wr_entry;
    logic [ENTRY_W-1:0]      rd_word;
    entry_t                  rd_entry;

    // Entry memory: key and handle side by side
    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full   = mid_sum[CW:1];
    assign fill_less1 = fill_reg - CW'(1);

    // Sequencer: search, then check or shift and write, then post the result
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        pos_next    = pos_reg;
        src_next    = src_reg;
        fill_next   = fill_reg;
        res_st_next = res_st_reg;
        res_fh_next = res_fh_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_full[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = src_reg + AW'(1);
        wr_entry    = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next     = op;
                    key_next    = key;
                    handle_next = record_handle;
                    lo_next     = '0;
                    hi_next     = fill_reg;
                    res_fh_next = '0;
                    if (op == OP_INSERT && fill_reg == CW'(DEPTH))
                    begin
                        res_st_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    // Probe the midpoint
                    rd_en      = 1'b1;
                    mid_next   = mid_full[AW-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    pos_next = lo_reg;
                    if (op_reg == OP_LOOKUP)
                    begin
                        if (lo_reg < fill_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = lo_reg[AW-1:0];
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            res_st_next = ST_MISSING;
                            state_next  = S_DONE;
                        end
                    end
                    else if (lo_reg == fill_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        src_next   = fill_less1[AW-1:0];
                        state_next = S_SH_RD;
                    end
                end
            end

            S_CMP:
            begin
                if (rd_entry.key < key_reg)
                begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    hi_next = CW'(mid_reg);
                end
                state_next = S_SRCH;
            end

            S_CHECK:
            begin
                if (rd_entry.key == key_reg)
                begin
                    res_st_next = ST_FOUND;
                    res_fh_next = rd_entry.handle;
                end
                else
                begin
                    res_st_next = ST_MISSING;
                end
                state_next = S_DONE;
            end

            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = src_reg;
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                // Move one entry up; reads never overtake this write
                wr_en = 1'b1;
                if (src_reg == pos_reg[AW-1:0])
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    src_next   = src_reg - AW'(1);
                    state_next = S_SH_RD;
                end
            end

            S_WRITE:
            begin
                wr_en           = 1'b1;
                wr_addr         = pos_reg[AW-1:0];
                wr_entry.key    = key_reg;
                wr_entry.handle = handle_reg;
                fill_next       = fill_reg + CW'(1);
                res_st_next     = ST_INSERTED;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on completion, drop after the transfer
    always_comb
    begin
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        found_handle_next = found_handle_reg;
        entry_count_next  = entry_count_reg;
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next    = 1'b1;
            status_next       = res_st_reg;
            found_handle_next = res_fh_reg;
            entry_count_next  = COUNT_W'(fill_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        key_reg          <= key_next;
        handle_reg       <= handle_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        mid_reg          <= mid_next;
        pos_reg          <= pos_next;
        src_reg          <= src_next;
        res_st_reg       <= res_st_next;
        res_fh_reg       <= res_fh_next;
        status_reg       <= status_next;
        found_handle_reg <= found_handle_next;
        entry_count_reg  <= entry_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_handle = found_handle_reg;
    assign entry_count  = entry_count_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("sequencer idle after accepting an item");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FOUND) |-> (found_handle == '0))
        else $error("handle not zero on a result without a match");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SH_WR || state_reg == S_WRITE))
        else $error("entry memory written outside the insert phases");
`endif

endmodule

// ===== sv/skt_ram.sv =====
module skt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
